// ===== rtl/lpct_pkg.sv =====
package lpct_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_ADD    = 3'd2,
    ACT_ZERO   = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_REWIND = 3'd5,
    ACT_NEXT   = 3'd6,
    ACT_NOP    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_ABSENT = 3'd1,
    ST_FULL   = 3'd2,
    ST_NULL   = 3'd3,
    ST_ENDED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MOD,
    S_PREP,
    S_PROBE,
    S_CHECK,
    S_WRITE,
    S_SWEEP,
    S_SCAN,
    S_SCHECK,
    S_OUT
  } state_t;

  localparam int unsigned HASH_MUL = 42283;
  localparam logic [11:0] SIZE_RESET = 12'd2017;
  localparam logic [10:0] MAXRES_RESET = 11'd1210;
  localparam int unsigned CFG_TABLE_SIZE = 0;
  localparam int unsigned CFG_MAX_RESIDENT = 1;

endpackage

// ===== rtl/lpct_ram.sv =====
module lpct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lpct_mod.sv =====
module lpct_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic [16:0] remainder
);

  logic [31:0] quo;
  logic [5:0]  cnt;
  logic [17:0] trial;

  assign trial = {remainder, quo[31]} - {1'b0, divisor};

  // Restoring remainder, one dividend bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      cnt       <= 6'd32;
      quo       <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (!trial[17]) begin
        remainder <= trial[16:0];
      end else begin
        remainder <= {remainder[15:0], quo[31]};
      end
      quo <= {quo[30:0], 1'b0};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/linear_probe_count_table.sv =====
// Key-to-count hash table with linear probing. Keys and counts sit in two
// synchronous RAMs of SLOTS entries. An insert, lookup or add runs the hash
// multiply and the bit-serial modulo, then reads and checks one probed slot
// after another, writes back where needed and loads the result register.
// Zero counts and clear all sweep the whole memory, one slot a cycle; next
// examines slots in turn up to the first used one or the table's end. After
// reset a clearing pass over all SLOTS entries runs before the first
// transaction is accepted. One transaction is worked on at a time; the
// result waits in an output register; the next one is taken once it has left.
module linear_probe_count_table #(
  parameter int SLOTS    = 2048,
  parameter int KEY_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[2:0], key[66:3], increment[98:67], zero padding to 104 bits
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], inserted[3], slot[14:4], key_out[78:15], count_out[142:79]
  output logic [143:0] m_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [11:0]  cfg_data
);
  import lpct_pkg::*;

  localparam int AW = $clog2(SLOTS);

  state_t state, state_next;

  logic [11:0] size_cfg;
  logic [10:0] max_resident;
  logic [16:0] resident;
  logic [AW:0] scan_pos;

  action_t     act;
  logic [63:0] key;
  logic [63:0] incr;
  logic [31:0] hprod;
  logic [AW:0] idx;
  logic [AW:0] steps;
  logic [AW:0] sweep;
  logic        sweep_keys;

  logic [2:0]  r_status;
  logic        r_ins;
  logic [10:0] r_slot;
  logic [63:0] r_key;
  logic [63:0] r_count;

  logic [AW:0] eff;
  logic [16:0] eff_w;

  // Effective size clamped to the range 2 .. SLOTS.
  always_comb begin
    if (size_cfg < 12'd2) begin
      eff_w = 17'd2;
    end else if (32'(size_cfg) > 32'(SLOTS)) begin
      eff_w = 17'(SLOTS);
    end else begin
      eff_w = 17'(size_cfg);
    end
    eff = eff_w[AW:0];
  end

  // Memories and their ports.
  logic          k_we, c_we;
  logic [AW-1:0] k_wa, c_wa, rd_a;
  logic [63:0]   k_wd, c_wd, k_rd, c_rd;

  lpct_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(rd_a), .rdata(k_rd)
  );
  lpct_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_counts (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(rd_a), .rdata(c_rd)
  );

  logic        md_start, md_busy;
  logic [16:0] md_rem;
  lpct_mod u_mod (
    .clk(clk), .rst(rst), .start(md_start), .dividend(hprod),
    .divisor(eff_w), .busy(md_busy), .remainder(md_rem)
  );

  logic [63:0] key_mask;
  assign key_mask = {64{1'b1}} >> (64 - KEY_BITS);

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {1'b0, r_count, r_key, r_slot, r_ins, r_status};
  assign rd_a     = (state == S_SCAN) ? scan_pos[AW-1:0] : idx[AW-1:0];

  logic        kmatch, kempty;
  logic [63:0] csum;
  assign kmatch = (k_rd == key);
  assign kempty = (k_rd == 64'd0);
  assign csum   = c_rd + incr;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          unique case (action_t'(s_tdata[2:0]))
            ACT_INSERT, ACT_LOOKUP, ACT_ADD: begin
              if ((s_tdata[66:3] & key_mask) == 64'd0) state_next = S_OUT;
              else state_next = S_MUL;
            end
            ACT_ZERO, ACT_CLEAR: state_next = S_SWEEP;
            ACT_NEXT: state_next = S_SCAN;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_MUL:   state_next = S_MOD;
      S_MOD:   if (!md_busy && !md_start) state_next = S_PREP;
      S_PREP:  state_next = S_PROBE;
      S_PROBE: state_next = S_CHECK;
      S_CHECK: begin
        if (kmatch || kempty || steps == eff - 1'b1) state_next = S_WRITE;
        else state_next = S_PROBE;
      end
      S_WRITE: state_next = S_OUT;
      // The clearing pass after reset has no transaction to answer.
      S_SWEEP: begin
        if (sweep == (AW+1)'(SLOTS - 1)) begin
          state_next = (act == ACT_NOP) ? S_IDLE : S_OUT;
        end
      end
      S_SCAN: begin
        if (resident == 17'd0 || scan_pos >= eff) state_next = S_OUT;
        else state_next = S_SCHECK;
      end
      S_SCHECK: state_next = kempty ? S_SCAN : S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory write controls.
  always_comb begin
    k_we = 1'b0; c_we = 1'b0;
    k_wa = idx[AW-1:0]; c_wa = idx[AW-1:0];
    k_wd = key; c_wd = 64'd0;
    md_start = (state == S_MUL);
    unique case (state)
      S_SWEEP: begin
        c_we = 1'b1; c_wa = sweep[AW-1:0];
        k_we = sweep_keys; k_wa = sweep[AW-1:0]; k_wd = 64'd0;
      end
      S_CHECK: begin
        if (kmatch && act == ACT_ADD) begin
          c_we = 1'b1; c_wd = csum;
        end else if (!kmatch && kempty && act == ACT_INSERT &&
                     resident <= 17'(max_resident)) begin
          k_we = 1'b1; c_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep        <= '0;
      sweep_keys   <= 1'b1;
      size_cfg     <= SIZE_RESET;
      max_resident <= MAXRES_RESET;
      resident     <= '0;
      scan_pos     <= '0;
      m_tvalid     <= 1'b0;
      act          <= ACT_NOP;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_TABLE_SIZE)) size_cfg <= cfg_data;
        else max_resident <= cfg_data[10:0];
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == S_OUT) m_tvalid <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            act        <= action_t'(s_tdata[2:0]);
            key        <= s_tdata[66:3] & key_mask;
            incr       <= {{32{s_tdata[98]}}, s_tdata[98:67]};
            // Only the low 32 bits of the product feed the hash.
            hprod      <= (s_tdata[34:3] & key_mask[31:0]) * 32'(HASH_MUL);
            sweep      <= '0;
            sweep_keys <= (action_t'(s_tdata[2:0]) == ACT_CLEAR);
            r_ins      <= 1'b0;
            r_slot     <= '0;
            r_count    <= '0;
            if ((action_t'(s_tdata[2:0]) == ACT_INSERT ||
                 action_t'(s_tdata[2:0]) == ACT_LOOKUP ||
                 action_t'(s_tdata[2:0]) == ACT_ADD) &&
                (s_tdata[66:3] & key_mask) == 64'd0) begin
              r_status <= ST_NULL;
            end else begin
              r_status <= ST_DONE;
            end
            if (action_t'(s_tdata[2:0]) == ACT_NEXT) r_key <= '0;
            else r_key <= s_tdata[66:3] & key_mask;
            if (action_t'(s_tdata[2:0]) == ACT_REWIND) scan_pos <= '0;
            if (action_t'(s_tdata[2:0]) == ACT_CLEAR) resident <= '0;
          end
        end
        S_PREP: begin
          idx   <= md_rem[AW:0];
          steps <= '0;
        end
        S_CHECK: begin
          if (kmatch) begin
            r_slot <= 11'(idx);
            if (act == ACT_ADD) r_count <= csum;
            else if (act == ACT_LOOKUP) r_count <= c_rd;
          end else if (kempty || steps == eff - 1'b1) begin
            if (act != ACT_INSERT) r_status <= ST_ABSENT;
            else if (!kempty || resident > 17'(max_resident)) r_status <= ST_FULL;
            else begin
              resident <= resident + 17'd1;
              r_ins    <= 1'b1;
              r_slot   <= 11'(idx);
            end
          end else begin
            steps <= steps + 1'b1;
            idx   <= (idx + 1'b1 == eff) ? '0 : idx + 1'b1;
          end
        end
        S_SWEEP: sweep <= sweep + 1'b1;
        S_SCAN: begin
          if (resident == 17'd0 || scan_pos >= eff) r_status <= ST_ENDED;
        end
        S_SCHECK: begin
          if (kempty) begin
            scan_pos <= scan_pos + 1'b1;
          end else begin
            r_slot   <= 11'(scan_pos);
            r_key    <= k_rd;
            r_count  <= c_rd;
            scan_pos <= scan_pos + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb_linear_probe_count_table.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_count_table;
  import lpct_pkg::*;

  localparam int NSLOTS = 2048;
  localparam int RX_HOLD = 300;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct packed {
    status_t            status;
    logic               inserted;
    logic [10:0]        slot;
    logic [63:0]        key;
    logic signed [63:0] count;
  } table_reply_t;

  typedef struct {
    action_t      act;
    logic [63:0]  key;
    logic [31:0]  incr;
    bit           typed;
    table_reply_t want;
  } op_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // action[2:0], key[66:3], increment[98:67], zero padding to 104 bits
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // status[2:0], inserted[3], slot[14:4], key_out[78:15], count_out[142:79]
  logic [143:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [11:0]  cfg_data = '0;

  linear_probe_count_table dut (.*);

  // Clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [63:0]        shadow_keys [NSLOTS];
  logic signed [63:0] shadow_counts [NSLOTS];
  int unsigned        resident;
  int unsigned        scan_pos;
  int unsigned        size_reg;
  int unsigned        maxres_reg;

  table_reply_t pending_replies[$];
  int           errors = 0;
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;
  int           rx_gap = 0;
  longint       cycles = 0;
  logic [63:0]  key_pool[$];

  function automatic int unsigned live_size();
    if (size_reg < 2) return 2;
    if (size_reg > NSLOTS) return NSLOTS;
    return size_reg;
  endfunction

  // Works out the reply to one transaction and updates the shadow table.
  function automatic table_reply_t table_apply(action_t act, logic [63:0] key,
                                               logic [31:0] incr);
    table_reply_t r;
    int unsigned sz, home, idx, where;
    int found;
    logic [63:0] prod;
    r.status = ST_DONE;
    r.inserted = 1'b0;
    r.slot = '0;
    r.key = key;
    r.count = '0;
    sz = live_size();
    case (act)
      ACT_INSERT, ACT_LOOKUP, ACT_ADD: begin
        if (key == '0) begin
          r.status = ST_NULL;
        end else begin
          prod = key * 64'd42283;
          home = prod[31:0] % sz;
          found = -1;
          where = 0;
          for (int i = 0; i < sz; i++) begin
            idx = (home + i) % sz;
            if (shadow_keys[idx] == key) begin
              found = 1;
              where = idx;
              break;
            end
            if (shadow_keys[idx] == '0) begin
              found = 0;
              where = idx;
              break;
            end
          end
          if (found == 1) begin
            r.slot = where[10:0];
            if (act == ACT_ADD)
              shadow_counts[where] = shadow_counts[where] + 64'(signed'(incr));
            if (act != ACT_INSERT) r.count = shadow_counts[where];
          end else if (act != ACT_INSERT) begin
            r.status = ST_ABSENT;
          end else if (found < 0 || resident > maxres_reg) begin
            r.status = ST_FULL;
          end else begin
            shadow_keys[where] = key;
            shadow_counts[where] = '0;
            resident++;
            r.inserted = 1'b1;
            r.slot = where[10:0];
          end
        end
      end
      ACT_ZERO: begin
        foreach (shadow_counts[i]) shadow_counts[i] = '0;
      end
      ACT_CLEAR: begin
        foreach (shadow_keys[i]) begin
          shadow_keys[i] = '0;
          shadow_counts[i] = '0;
        end
        resident = 0;
      end
      ACT_REWIND: scan_pos = 0;
      ACT_NEXT: begin
        r.key = '0;
        if (resident == 0 || scan_pos >= sz) begin
          r.status = ST_ENDED;
        end else begin
          while (shadow_keys[scan_pos] == '0) begin
            scan_pos++;
            if (scan_pos >= sz) break;
          end
          if (scan_pos >= sz) begin
            r.status = ST_ENDED;
          end else begin
            r.slot = scan_pos[10:0];
            r.key = shadow_keys[scan_pos];
            r.count = shadow_counts[scan_pos];
            scan_pos++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offers one transaction and waits for it to be taken.
  task automatic send_op(action_t act, logic [63:0] key, logic [31:0] incr,
                         bit typed, table_reply_t want);
    table_reply_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, incr, key, act};
    do @(posedge clk); while (!s_tready);
    got = table_apply(act, key, incr);
    pending_replies.push_back(typed ? want : got);
  endtask

  // Waits until every reply has left, then writes one register.
  task automatic write_reg(int unsigned idx, int unsigned value);
    s_tvalid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx[0:0];
    cfg_data <= value[11:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TABLE_SIZE) size_reg = value;
    else maxres_reg = value;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // One random transaction, mostly on keys that are already in play.
  task automatic send_random();
    int unsigned pick;
    action_t act;
    logic [63:0] key;
    table_reply_t none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (pick < 30) act = ACT_INSERT;
    else if (pick < 55) act = ACT_LOOKUP;
    else if (pick < 80) act = ACT_ADD;
    else if (pick < 90) act = ACT_NEXT;
    else if (pick < 94) act = ACT_REWIND;
    else if (pick < 96) act = ACT_ZERO;
    else if (pick < 98) act = ACT_CLEAR;
    else act = ACT_NOP;
    pick = $urandom_range(0, 99);
    if (pick < 80) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    else if (pick < 97) key = rand_key();
    else key = '0;
    send_op(act, key, $urandom(), 1'b0, none);
  endtask

  task automatic run_phase(int unsigned sz, int unsigned mr, int n, int pool);
    table_reply_t none;
    logic [63:0] k;
    none = '0;
    write_reg(CFG_TABLE_SIZE, sz);
    write_reg(CFG_MAX_RESIDENT, mr);
    key_pool.delete();
    while (key_pool.size() < pool) begin
      k = rand_key();
      if (k != '0) key_pool.push_back(k);
    end
    send_op(ACT_CLEAR, '0, '0, 1'b0, none);
    for (int i = 0; i < n; i++) send_random();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_gap = RX_HOLD;
    end else if (rx_gap == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 11);
    end
    if (rx_gap != 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Reply checker.
  always @(posedge clk) begin
    table_reply_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[2:0]);
      got.inserted = m_tdata[3];
      got.slot = m_tdata[14:4];
      got.key = m_tdata[78:15];
      got.count = m_tdata[142:79];
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none expected, got %h", $time, got);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.inserted !== want.inserted) begin
          $display("%0t: inserted expected %0d got %0d", $time, want.inserted,
                   got.inserted);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, want.slot, got.slot);
          errors++;
        end
        if (got.key !== want.key) begin
          $display("%0t: key expected %h got %h", $time, want.key, got.key);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("linear_probe_count_table regression: fail");
      $finish;
    end
  end

  function automatic table_reply_t reply(status_t st, logic [63:0] k);
    table_reply_t r;
    r = '0;
    r.status = st;
    r.key = k;
    return r;
  endfunction

  initial begin
    op_row_t rows[$];
    table_reply_t none;
    logic [63:0] ones;
    none = '0;
    ones = '1;
    foreach (shadow_keys[i]) begin
      shadow_keys[i] = '0;
      shadow_counts[i] = '0;
    end
    resident = 0;
    scan_pos = 0;
    size_reg = SIZE_RESET;
    maxres_reg = MAXRES_RESET;

    // Directed rows; typed replies only where obvious.
    rows = '{
      '{ACT_NEXT,   64'd0,      32'd0,          1, reply(ST_ENDED, 64'd0)},
      '{ACT_LOOKUP, 64'd5,      32'd0,          1, reply(ST_ABSENT, 64'd5)},
      '{ACT_INSERT, 64'd0,      32'd0,          1, reply(ST_NULL, 64'd0)},
      '{ACT_ADD,    64'd0,      32'd7,          1, reply(ST_NULL, 64'd0)},
      '{ACT_LOOKUP, 64'd0,      32'd0,          1, reply(ST_NULL, 64'd0)},
      '{ACT_ADD,    ones,       32'd3,          1, reply(ST_ABSENT, ones)},
      '{ACT_INSERT, ones,       32'd0,          0, none},
      '{ACT_INSERT, 64'd1,      32'd0,          0, none},
      '{ACT_INSERT, ones,       32'd0,          0, none},
      '{ACT_ADD,    ones,       32'h7fffffff,   0, none},
      '{ACT_ADD,    ones,       32'h80000000,   0, none},
      '{ACT_ADD,    ones,       32'hffffffff,   0, none},
      '{ACT_ADD,    64'd1,      32'h80000000,   0, none},
      '{ACT_LOOKUP, ones,       32'd0,          0, none},
      '{ACT_REWIND, 64'd0,      32'd0,          1, reply(ST_DONE, 64'd0)},
      '{ACT_NEXT,   64'd0,      32'd0,          0, none},
      '{ACT_NEXT,   64'd0,      32'd0,          0, none},
      '{ACT_NEXT,   64'd0,      32'd0,          0, none},
      '{ACT_ZERO,   64'd0,      32'd0,          0, none},
      '{ACT_LOOKUP, 64'd1,      32'd0,          0, none},
      '{ACT_NOP,    64'h1234,   32'd9,          1, reply(ST_DONE, 64'h1234)},
      '{ACT_CLEAR,  64'd0,      32'd0,          0, none},
      '{ACT_NEXT,   64'd0,      32'd0,          1, reply(ST_ENDED, 64'd0)},
      '{ACT_LOOKUP, 64'd1,      32'd0,          1, reply(ST_ABSENT, 64'd1)}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_op(rows[i].act, rows[i].key, rows[i].incr,
                              rows[i].typed, rows[i].want);

    // Random phases over several register settings.
    run_phase(2017, 1210, 300, 40);
    run_phase(2, 1, 200, 4);
    run_phase(13, 2046, 400, 20);
    run_phase(2048, 2046, 300, 60);
    run_phase(61, 30, 300, 50);
    // Long receiver hold-off while transactions keep coming.
    hold_req = 1'b1;
    repeat (100) send_random();
    idle_on = 1'b0;
    run_phase(7, 5, 400, 12);

    s_tvalid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("linear_probe_count_table regression: pass");
    end else begin
      $display("linear_probe_count_table regression: fail");
    end
    $finish;
  end

endmodule
